// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SPCR_ASSERT_NOW(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define SPCR_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/spcr_pkg.sv =====
// Types, constants and arithmetic helpers of the sphere pair collision pipeline
package spcr_pkg;

    localparam int FIELD_W    = 24;
    localparam int D_W        = FIELD_W + 1;
    localparam int D2_W       = 2 * D_W;
    localparam int ROOT_W     = D2_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int RADIUS_W   = 20;
    localparam int REST_W     = 17;
    localparam int REST_FRAC  = 16;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int ACC_W      = 96;
    localparam int FIELD_MAX  = 8388607;
    localparam int FIELD_MIN  = -8388608;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 20'd32768;
    localparam logic [REST_W-1:0]   REST_RST   = 17'd29491;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS,
        CFG_REST
    } cfg_idx_t;

    typedef struct packed {
        logic [11:0][FIELD_W-1:0] pl;
        logic [2:0][D_W-1:0]      d;
        logic [2:0][D_W-1:0]      dv;
    } carry_t;

    function automatic logic signed [ACC_W-1:0] round_shift(
        input logic signed [ACC_W-1:0] v,
        input int unsigned             sh
    );
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        mag = v[ACC_W-1] ? ACC_W'(0) - v : v;
        r   = (mag + (ACC_W'(1) << (sh - 1))) >> sh;
        return v[ACC_W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [FIELD_W-1:0] sat(input logic signed [ACC_W-1:0] v);
        logic [FIELD_W-1:0] res;
        if (v > ACC_W'(FIELD_MAX))
        begin
            res = FIELD_W'(FIELD_MAX);
        end
        else if (v < ACC_W'(FIELD_MIN))
        begin
            res = FIELD_W'(FIELD_MIN);
        end
        else
        begin
            res = v[FIELD_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/spcr_in_if.sv =====
// Input channel: one sphere pair per transfer
interface spcr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [spcr_pkg::FIELD_W-1:0] a_pos_x;
    logic signed [spcr_pkg::FIELD_W-1:0] a_pos_y;
    logic signed [spcr_pkg::FIELD_W-1:0] a_pos_z;
    logic signed [spcr_pkg::FIELD_W-1:0] b_pos_x;
    logic signed [spcr_pkg::FIELD_W-1:0] b_pos_y;
    logic signed [spcr_pkg::FIELD_W-1:0] b_pos_z;
    logic signed [spcr_pkg::FIELD_W-1:0] a_vel_x;
    logic signed [spcr_pkg::FIELD_W-1:0] a_vel_y;
    logic signed [spcr_pkg::FIELD_W-1:0] a_vel_z;
    logic signed [spcr_pkg::FIELD_W-1:0] b_vel_x;
    logic signed [spcr_pkg::FIELD_W-1:0] b_vel_y;
    logic signed [spcr_pkg::FIELD_W-1:0] b_vel_z;

    modport source (
        output valid, a_pos_x, a_pos_y, a_pos_z, b_pos_x, b_pos_y, b_pos_z,
               a_vel_x, a_vel_y, a_vel_z, b_vel_x, b_vel_y, b_vel_z,
        input  ready
    );
    modport sink (
        input  valid, a_pos_x, a_pos_y, a_pos_z, b_pos_x, b_pos_y, b_pos_z,
               a_vel_x, a_vel_y, a_vel_z, b_vel_x, b_vel_y, b_vel_z,
        output ready
    );
endinterface

// ===== rtl/core/spcr_out_if.sv =====
// Output channel: one resolved sphere pair per transfer
interface spcr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [spcr_pkg::FIELD_W-1:0] new_a_pos_x;
    logic signed [spcr_pkg::FIELD_W-1:0] new_a_pos_y;
    logic signed [spcr_pkg::FIELD_W-1:0] new_a_pos_z;
    logic signed [spcr_pkg::FIELD_W-1:0] new_b_pos_x;
    logic signed [spcr_pkg::FIELD_W-1:0] new_b_pos_y;
    logic signed [spcr_pkg::FIELD_W-1:0] new_b_pos_z;
    logic signed [spcr_pkg::FIELD_W-1:0] new_a_vel_x;
    logic signed [spcr_pkg::FIELD_W-1:0] new_a_vel_y;
    logic signed [spcr_pkg::FIELD_W-1:0] new_a_vel_z;
    logic signed [spcr_pkg::FIELD_W-1:0] new_b_vel_x;
    logic signed [spcr_pkg::FIELD_W-1:0] new_b_vel_y;
    logic signed [spcr_pkg::FIELD_W-1:0] new_b_vel_z;

    modport source (
        output valid, new_a_pos_x, new_a_pos_y, new_a_pos_z,
               new_b_pos_x, new_b_pos_y, new_b_pos_z,
               new_a_vel_x, new_a_vel_y, new_a_vel_z,
               new_b_vel_x, new_b_vel_y, new_b_vel_z,
        input  ready
    );
    modport sink (
        input  valid, new_a_pos_x, new_a_pos_y, new_a_pos_z,
               new_b_pos_x, new_b_pos_y, new_b_pos_z,
               new_a_vel_x, new_a_vel_y, new_a_vel_z,
               new_b_vel_x, new_b_vel_y, new_b_vel_z,
        output ready
    );
endinterface

// ===== rtl/core/sphere_pair_collision_resolve.sv =====
// Throughput: one pair per cycle while the output is not stalled; the 25 one-bit
// square-root stages and the FRAC_BITS + 1 one-bit divider stages are fully pipelined.
// A stalled output freezes every stage; nothing is lost or repeated.
// Reset clears all stage valid bits and loads radius 0.5 and restitution 0.45.
`include "assert_macros.svh"

module sphere_pair_collision_resolve #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    spcr_in_if.sink                                 pair_in,
    spcr_out_if.source                              pair_out,
    input  logic                                    cfg_wr_en,
    input  logic [spcr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [spcr_pkg::CFG_W-1:0]              cfg_wdata
);

    localparam int FIELD_W = spcr_pkg::FIELD_W;
    localparam int D_W     = spcr_pkg::D_W;
    localparam int D2_W    = spcr_pkg::D2_W;
    localparam int ROOT_W  = spcr_pkg::ROOT_W;
    localparam int REM_W   = spcr_pkg::REM_W;
    localparam int ACC_W   = spcr_pkg::ACC_W;
    localparam int SQ_N    = ROOT_W;
    localparam int DIV_N   = FRAC_BITS + 1;
    localparam int ST_C    = 3 + SQ_N;
    localparam int ST_P1   = ST_C + DIV_N + 1;
    localparam int LAST    = ST_P1 + 7;
    localparam int SUB_W   = (FRAC_BITS + 2 > D_W + 1) ? FRAC_BITS + 2 : D_W + 1;
    localparam int DIST_W  = SUB_W - 1;
    localparam int HALF_W  = SUB_W + 1;
    localparam int N_W     = FRAC_BITS + 2;
    localparam int PS_W    = N_W + HALF_W;
    localparam int PV_W    = D_W + N_W;
    localparam int SUM_W   = PV_W + 2;
    localparam int VN_W    = D_W + 3;
    localparam int F_W     = spcr_pkg::REST_W + 1;
    localparam int PI_W    = VN_W + F_W + 2;
    localparam int IMP_W   = VN_W + 1;
    localparam int PN_W    = N_W + IMP_W;
    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam longint EPS_L = (ONE_L + 5000) / 10000;
    localparam longint REST_ONE_L = longint'(1) << spcr_pkg::REST_FRAC;

    logic                     en;
    logic [LAST:0]            valid_reg;
    spcr_pkg::carry_t         car_reg [LAST];
    spcr_pkg::carry_t         car_next;
    logic [spcr_pkg::RADIUS_W-1:0] radius_reg;
    logic [spcr_pkg::REST_W-1:0]   rest_reg;

    logic [D2_W-1:0]          sq_reg [3];
    logic [D2_W-1:0]          sq_next [3];
    logic [D2_W-1:0]          d2_reg;

    logic [REM_W-1:0]         sq_rem_reg  [SQ_N];
    logic [ROOT_W-1:0]        sq_root_reg [SQ_N];
    logic [D2_W-1:0]          sq_rad_reg  [SQ_N];

    logic                     c_col_reg, c_col_next;
    logic [DIST_W-1:0]        c_dist_reg, c_dist_next;
    logic signed [HALF_W-1:0] c_half_reg, c_half_next;
    logic [2:0]               c_neg_reg, c_neg_next;
    logic [DIST_W-1:0]        c_mag_reg [3];
    logic [DIST_W-1:0]        c_mag_next [3];

    logic [DIST_W:0]          dv_rem_reg  [DIV_N][3];
    logic [DIV_N-1:0]         dv_q_reg    [DIV_N][3];
    logic [DIST_W-1:0]        dv_dist_reg [DIV_N];
    logic signed [HALF_W-1:0] dv_half_reg [DIV_N];
    logic                     dv_col_reg  [DIV_N];
    logic [2:0]               dv_neg_reg  [DIV_N];

    logic signed [N_W-1:0]    n_reg [6][3];
    logic signed [N_W-1:0]    n_next [3];
    logic [6:0]               col_reg;
    logic signed [HALF_W-1:0] half_reg;
    logic signed [PS_W-1:0]   ps_reg [3];
    logic signed [PS_W-1:0]   ps_next [3];
    logic signed [PV_W-1:0]   pv_reg [3];
    logic signed [PV_W-1:0]   pv_next [3];
    logic signed [HALF_W-1:0] s_reg [5][3];
    logic signed [HALF_W-1:0] s_next [3];
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [VN_W-1:0]   vn_reg, vn_next;
    logic signed [PI_W-1:0]   pi_reg, pi_next;
    logic [1:0]               app_reg;
    logic                     app_next;
    logic signed [IMP_W-1:0]  imp_reg, imp_next;
    logic signed [PN_W-1:0]   pn_reg [3];
    logic signed [PN_W-1:0]   pn_next [3];
    logic [11:0][FIELD_W-1:0] out_reg, out_next;

    // Global advance: the last stage is empty or being taken
    assign en            = !valid_reg[LAST] || pair_out.ready;
    assign pair_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= spcr_pkg::RADIUS_RST;
            rest_reg   <= spcr_pkg::REST_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                spcr_pkg::CFG_RADIUS: radius_reg <= cfg_wdata[spcr_pkg::RADIUS_W-1:0];
                spcr_pkg::CFG_REST:   rest_reg   <= cfg_wdata[spcr_pkg::REST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAST-1:0], pair_in.valid};
        end
    end

    always_comb
    begin
        car_next.pl[0]  = pair_in.a_pos_x;
        car_next.pl[1]  = pair_in.a_pos_y;
        car_next.pl[2]  = pair_in.a_pos_z;
        car_next.pl[3]  = pair_in.b_pos_x;
        car_next.pl[4]  = pair_in.b_pos_y;
        car_next.pl[5]  = pair_in.b_pos_z;
        car_next.pl[6]  = pair_in.a_vel_x;
        car_next.pl[7]  = pair_in.a_vel_y;
        car_next.pl[8]  = pair_in.a_vel_z;
        car_next.pl[9]  = pair_in.b_vel_x;
        car_next.pl[10] = pair_in.b_vel_y;
        car_next.pl[11] = pair_in.b_vel_z;
        car_next.d[0]   = D_W'(pair_in.b_pos_x) - D_W'(pair_in.a_pos_x);
        car_next.d[1]   = D_W'(pair_in.b_pos_y) - D_W'(pair_in.a_pos_y);
        car_next.d[2]   = D_W'(pair_in.b_pos_z) - D_W'(pair_in.a_pos_z);
        car_next.dv[0]  = D_W'(pair_in.b_vel_x) - D_W'(pair_in.a_vel_x);
        car_next.dv[1]  = D_W'(pair_in.b_vel_y) - D_W'(pair_in.a_vel_y);
        car_next.dv[2]  = D_W'(pair_in.b_vel_z) - D_W'(pair_in.a_vel_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            car_reg[0] <= car_next;
            for (int i = 1; i < LAST; i++)
            begin
                car_reg[i] <= car_reg[i-1];
            end
        end
    end

    // Squared distance
    always_comb
    begin
        logic signed [2*D_W-1:0] prod;
        for (int k = 0; k < 3; k++)
        begin
            prod       = $signed(car_reg[0].d[k]) * $signed(car_reg[0].d[k]);
            sq_next[k] = prod[D2_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            d2_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    // Square root, one result bit per stage
    for (genvar j = 0; j < SQ_N; j++)
    begin : g_sqrt
        logic [REM_W-1:0]  rem_i;
        logic [REM_W-1:0]  rem_t;
        logic [REM_W-1:0]  trial;
        logic [ROOT_W-1:0] root_i;
        logic [D2_W-1:0]   rad_i;

        if (j == 0)
        begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign rad_i  = d2_reg;
        end
        else
        begin : g_next
            assign rem_i  = sq_rem_reg[j-1];
            assign root_i = sq_root_reg[j-1];
            assign rad_i  = sq_rad_reg[j-1];
        end

        assign rem_t = {rem_i[REM_W-3:0], rad_i[D2_W-1 -: 2]};
        assign trial = {root_i, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_t >= trial)
                begin
                    sq_rem_reg[j]  <= rem_t - trial;
                    sq_root_reg[j] <= {root_i[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[j]  <= rem_t;
                    sq_root_reg[j] <= {root_i[ROOT_W-2:0], 1'b0};
                end
                sq_rad_reg[j] <= {rad_i[D2_W-3:0], 2'b00};
            end
        end
    end

    // Contact test, coincident-center fallback, half penetration
    always_comb
    begin
        logic [ROOT_W-1:0]        dist_raw;
        logic [spcr_pkg::RADIUS_W:0] mind;
        logic                     coin;
        logic signed [SUB_W-1:0]  dk;
        logic signed [HALF_W-1:0] diff;
        logic signed [HALF_W-1:0] diff_adj;
        dist_raw    = sq_root_reg[SQ_N-1];
        mind        = {radius_reg, 1'b0};
        c_col_next  = DIST_W'(dist_raw) < DIST_W'(mind);
        coin        = DIST_W'(dist_raw) <= DIST_W'(EPS_L);
        c_dist_next = coin ? DIST_W'(ONE_L) : DIST_W'(dist_raw);
        for (int k = 0; k < 3; k++)
        begin
            dk = SUB_W'($signed(car_reg[ST_C-1].d[k]));
            if (coin)
            begin
                dk = (k == 0) ? SUB_W'(ONE_L) : '0;
            end
            c_neg_next[k] = dk[SUB_W-1];
            c_mag_next[k] = dk[SUB_W-1] ? DIST_W'(-dk) : DIST_W'(dk);
        end
        diff        = $signed(HALF_W'(mind)) - $signed(HALF_W'(c_dist_next));
        diff_adj    = diff + $signed(HALF_W'(diff[HALF_W-1]));
        c_half_next = diff_adj >>> 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_col_reg  <= c_col_next;
            c_dist_reg <= c_dist_next;
            c_half_reg <= c_half_next;
            c_neg_reg  <= c_neg_next;
            for (int k = 0; k < 3; k++)
            begin
                c_mag_reg[k] <= c_mag_next[k];
            end
        end
    end

    // Normal components, one quotient bit per stage
    for (genvar s = 0; s < DIV_N; s++)
    begin : g_div
        logic [DIST_W-1:0]        dist_i;
        logic signed [HALF_W-1:0] half_i;
        logic                     col_i;
        logic [2:0]               neg_i;

        if (s == 0)
        begin : g_first
            assign dist_i = c_dist_reg;
            assign half_i = c_half_reg;
            assign col_i  = c_col_reg;
            assign neg_i  = c_neg_reg;
        end
        else
        begin : g_next
            assign dist_i = dv_dist_reg[s-1];
            assign half_i = dv_half_reg[s-1];
            assign col_i  = dv_col_reg[s-1];
            assign neg_i  = dv_neg_reg[s-1];
        end

        for (genvar k = 0; k < 3; k++)
        begin : g_axis
            logic [DIST_W:0]  rem_t;
            logic [DIV_N-1:0] q_i;

            if (s == 0)
            begin : g_first
                assign rem_t = {1'b0, c_mag_reg[k][DIST_W-1:1], c_mag_reg[k][0]};
                assign q_i   = '0;
            end
            else
            begin : g_next
                assign rem_t = {dv_rem_reg[s-1][k][DIST_W-1:0], 1'b0};
                assign q_i   = dv_q_reg[s-1][k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem_t >= {1'b0, dist_i})
                    begin
                        dv_rem_reg[s][k] <= rem_t - {1'b0, dist_i};
                        dv_q_reg[s][k]   <= {q_i[DIV_N-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[s][k] <= rem_t;
                        dv_q_reg[s][k]   <= {q_i[DIV_N-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_dist_reg[s] <= dist_i;
                dv_half_reg[s] <= half_i;
                dv_col_reg[s]  <= col_i;
                dv_neg_reg[s]  <= neg_i;
            end
        end
    end

    // Position shift, closing speed, impulse, update
    always_comb
    begin
        logic signed [ACC_W-1:0] r;
        logic signed [N_W-1:0]   qs;
        logic [F_W-1:0]          fq;
        logic signed [VN_W:0]    nvn;
        logic signed [IMP_W-1:0] imp_k;
        for (int k = 0; k < 3; k++)
        begin
            qs        = $signed(N_W'(dv_q_reg[DIV_N-1][k]));
            n_next[k] = dv_neg_reg[DIV_N-1][k] ? -qs : qs;
            ps_next[k] = n_reg[0][k] * half_reg;
            pv_next[k] = n_reg[0][k] * $signed(car_reg[ST_P1].dv[k]);
            r          = spcr_pkg::round_shift(ACC_W'(ps_reg[k]), FRAC_BITS);
            s_next[k]  = r[HALF_W-1:0];
            pn_next[k] = n_reg[5][k] * imp_reg;
        end
        sum_next = SUM_W'(pv_reg[0]) + SUM_W'(pv_reg[1]) + SUM_W'(pv_reg[2]);
        r        = spcr_pkg::round_shift(ACC_W'(sum_reg), FRAC_BITS);
        vn_next  = r[VN_W-1:0];
        fq       = F_W'(rest_reg) + F_W'(REST_ONE_L);
        app_next = vn_reg[VN_W-1] || (vn_reg == '0);
        nvn      = -((VN_W+1)'(vn_reg));
        pi_next  = app_next ? nvn * $signed({1'b0, fq}) : '0;
        r        = spcr_pkg::round_shift(ACC_W'(pi_reg), spcr_pkg::REST_FRAC + 1);
        imp_next = r[IMP_W-1:0];
        for (int k = 0; k < 3; k++)
        begin
            r     = spcr_pkg::round_shift(ACC_W'(pn_reg[k]), FRAC_BITS);
            imp_k = r[IMP_W-1:0];
            out_next[k]     = car_reg[LAST-1].pl[k];
            out_next[3 + k] = car_reg[LAST-1].pl[3 + k];
            out_next[6 + k] = car_reg[LAST-1].pl[6 + k];
            out_next[9 + k] = car_reg[LAST-1].pl[9 + k];
            if (col_reg[6])
            begin
                out_next[k] = spcr_pkg::sat(ACC_W'($signed(car_reg[LAST-1].pl[k]))
                                            - ACC_W'(s_reg[4][k]));
                out_next[3 + k] = spcr_pkg::sat(ACC_W'($signed(car_reg[LAST-1].pl[3 + k]))
                                                + ACC_W'(s_reg[4][k]));
                out_next[6 + k] = spcr_pkg::sat(ACC_W'($signed(car_reg[LAST-1].pl[6 + k]))
                                                - ACC_W'(imp_k));
                out_next[9 + k] = spcr_pkg::sat(ACC_W'($signed(car_reg[LAST-1].pl[9 + k]))
                                                + ACC_W'(imp_k));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            half_reg   <= dv_half_reg[DIV_N-1];
            col_reg    <= {col_reg[5:0], dv_col_reg[DIV_N-1]};
            for (int k = 0; k < 3; k++)
            begin
                n_reg[0][k] <= n_next[k];
                for (int p = 1; p < 6; p++)
                begin
                    n_reg[p][k] <= n_reg[p-1][k];
                end
                ps_reg[k]   <= ps_next[k];
                pv_reg[k]   <= pv_next[k];
                s_reg[0][k] <= s_next[k];
                for (int p = 1; p < 5; p++)
                begin
                    s_reg[p][k] <= s_reg[p-1][k];
                end
                pn_reg[k]   <= pn_next[k];
            end
            sum_reg <= sum_next;
            vn_reg  <= vn_next;
            pi_reg  <= pi_next;
            app_reg <= {app_reg[0], app_next};
            imp_reg <= imp_next;
            out_reg <= out_next;
        end
    end

    assign pair_out.valid       = valid_reg[LAST];
    assign pair_out.new_a_pos_x = $signed(out_reg[0]);
    assign pair_out.new_a_pos_y = $signed(out_reg[1]);
    assign pair_out.new_a_pos_z = $signed(out_reg[2]);
    assign pair_out.new_b_pos_x = $signed(out_reg[3]);
    assign pair_out.new_b_pos_y = $signed(out_reg[4]);
    assign pair_out.new_b_pos_z = $signed(out_reg[5]);
    assign pair_out.new_a_vel_x = $signed(out_reg[6]);
    assign pair_out.new_a_vel_y = $signed(out_reg[7]);
    assign pair_out.new_a_vel_z = $signed(out_reg[8]);
    assign pair_out.new_b_vel_x = $signed(out_reg[9]);
    assign pair_out.new_b_vel_y = $signed(out_reg[10]);
    assign pair_out.new_b_vel_z = $signed(out_reg[11]);

    `SPCR_ASSERT_NEXT(a_stall_hold, clk, rst_n, !en, valid_reg == $past(valid_reg))
    `SPCR_ASSERT_NEXT(a_pass_through, clk, rst_n, en && valid_reg[LAST-1] && !col_reg[6],
        out_reg[6] == $past(car_reg[LAST-1].pl[6]))
    `SPCR_ASSERT_NOW(a_no_impulse, clk, rst_n, valid_reg[ST_P1+5] && !app_reg[1],
        imp_reg == '0)

endmodule

// ===== tb/tb_sphere_pair_collision_resolve.sv =====
// Testbench of the sphere pair collision pipeline: random and directed pairs against a predictor
module tb_sphere_pair_collision_resolve;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_W   = spcr_pkg::FIELD_W;
    localparam int CFG_W     = spcr_pkg::CFG_W;
    localparam int CFG_IDX_W = spcr_pkg::CFG_IDX_W;
    localparam int REST_W    = spcr_pkg::REST_W;
    localparam int REST_FRAC = spcr_pkg::REST_FRAC;

    typedef logic [11:0][FIELD_W-1:0] pair_t;

    localparam longint ONE_Q = 65536;
    localparam longint EPS_Q = (65536 + 5000) / 10000;
    localparam int MAX_FIELD = 8388607;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = spcr_pkg::CFG_RADIUS;
    logic [CFG_W-1:0] cfg_wdata = '0;

    spcr_in_if pin ();
    spcr_out_if pout ();

    sphere_pair_collision_resolve u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair_in   (pin),
        .pair_out  (pout),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    string field_name [12] = '{"new_a_pos_x", "new_a_pos_y", "new_a_pos_z",
                               "new_b_pos_x", "new_b_pos_y", "new_b_pos_z",
                               "new_a_vel_x", "new_a_vel_y", "new_a_vel_z",
                               "new_b_vel_x", "new_b_vel_y", "new_b_vel_z"};

    longint radius_q = 32768;
    longint rest_q = 29491;
    pair_t pending_pairs [$];
    pair_t resolved_pairs [$];
    int errors = 0;
    int accepted = 0;
    int checked = 0;
    int collided = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;

    function automatic longint rnd_shr(longint v, int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [FIELD_W-1:0] clamp24(longint v);
        if (v > MAX_FIELD)
            v = MAX_FIELD;
        if (v < -MAX_FIELD - 1)
            v = -MAX_FIELD - 1;
        return v[FIELD_W-1:0];
    endfunction

    function automatic pair_t resolve_pair(pair_t p, ref int hits);
        longint ap [3], bp [3], av [3], bv [3], d [3], n [3];
        longint sep, mind, half, vn, imp, sum, s, f;
        longint unsigned d2;
        pair_t r;
        sum = 0;
        d2 = 0;
        for (int k = 0; k < 3; k++)
        begin
            ap[k] = longint'($signed(p[k]));
            bp[k] = longint'($signed(p[3 + k]));
            av[k] = longint'($signed(p[6 + k]));
            bv[k] = longint'($signed(p[9 + k]));
            d[k] = bp[k] - ap[k];
            d2 += longint'(d[k] * d[k]);
        end
        sep = int_sqrt(d2);
        mind = radius_q * 2;
        if (sep < mind)
        begin
            hits++;
            if (sep <= EPS_Q)
            begin
                d[0] = ONE_Q;
                d[1] = 0;
                d[2] = 0;
                sep = ONE_Q;
            end
            for (int k = 0; k < 3; k++)
                n[k] = (d[k] * ONE_Q) / sep;
            half = (mind - sep) / 2;
            for (int k = 0; k < 3; k++)
            begin
                s = rnd_shr(n[k] * half, 16);
                ap[k] -= s;
                bp[k] += s;
            end
            for (int k = 0; k < 3; k++)
                sum += (bv[k] - av[k]) * n[k];
            vn = rnd_shr(sum, 16);
            if (vn <= 0)
            begin
                f = rest_q + (longint'(1) << REST_FRAC);
                imp = rnd_shr(-vn * f, REST_FRAC + 1);
                for (int k = 0; k < 3; k++)
                begin
                    s = rnd_shr(n[k] * imp, 16);
                    av[k] -= s;
                    bv[k] += s;
                end
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            r[k] = clamp24(ap[k]);
            r[3 + k] = clamp24(bp[k]);
            r[6 + k] = clamp24(av[k]);
            r[9 + k] = clamp24(bv[k]);
        end
        return r;
    endfunction

    // sender: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        pair_t item;
        if (!rst_n)
        begin
            pin.valid <= 1'b0;
            {pin.a_pos_x, pin.a_pos_y, pin.a_pos_z, pin.b_pos_x, pin.b_pos_y, pin.b_pos_z,
             pin.a_vel_x, pin.a_vel_y, pin.a_vel_z, pin.b_vel_x, pin.b_vel_y,
             pin.b_vel_z} <= '0;
        end
        else if (!pin.valid || pin.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                pin.valid <= 1'b0;
            end
            else if (pending_pairs.size() > 0)
            begin
                item = pending_pairs.pop_front();
                pin.a_pos_x <= item[0];
                pin.a_pos_y <= item[1];
                pin.a_pos_z <= item[2];
                pin.b_pos_x <= item[3];
                pin.b_pos_y <= item[4];
                pin.b_pos_z <= item[5];
                pin.a_vel_x <= item[6];
                pin.a_vel_y <= item[7];
                pin.a_vel_z <= item[8];
                pin.b_vel_x <= item[9];
                pin.b_vel_y <= item[10];
                pin.b_vel_z <= item[11];
                pin.valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                pin.valid <= 1'b0;
            end
        end
    end

    // record the expectation of every input transfer
    always @(posedge clk)
    begin
        pair_t got;
        if (rst_n && pin.valid && pin.ready)
        begin
            got = {pin.b_vel_z, pin.b_vel_y, pin.b_vel_x, pin.a_vel_z, pin.a_vel_y,
                   pin.a_vel_x, pin.b_pos_z, pin.b_pos_y, pin.b_pos_x, pin.a_pos_z,
                   pin.a_pos_y, pin.a_pos_x};
            resolved_pairs.push_back(resolve_pair(got, collided));
            accepted++;
        end
    end

    // receiver: own stall pattern plus one long hold
    int pat_left = 0;
    int stall_pct = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pout.ready <= 1'b0;
        end
        else
        begin
            if (!hold_done && accepted >= 40)
            begin
                hold_done = 1'b1;
                hold_cnt = 300;
            end
            if (pat_left == 0)
            begin
                pat_left = $urandom_range(5, 60);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
            end
            else
            begin
                pat_left--;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                pout.ready <= 1'b0;
            end
            else
            begin
                pout.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // compare output transfers against the oldest expectation
    always @(posedge clk)
    begin
        pair_t got;
        pair_t want;
        if (rst_n && pout.valid && pout.ready)
        begin
            got = {pout.new_b_vel_z, pout.new_b_vel_y, pout.new_b_vel_x, pout.new_a_vel_z,
                   pout.new_a_vel_y, pout.new_a_vel_x, pout.new_b_pos_z, pout.new_b_pos_y,
                   pout.new_b_pos_x, pout.new_a_pos_z, pout.new_a_pos_y, pout.new_a_pos_x};
            if (resolved_pairs.size() == 0)
            begin
                $error("output transfer with no expected pair");
                errors++;
            end
            else
            begin
                want = resolved_pairs.pop_front();
                checked++;
                for (int k = 0; k < 12; k++)
                begin
                    if (got[k] !== want[k])
                    begin
                        $error("%s expected %0d actual %0d", field_name[k],
                               $signed(want[k]), $signed(got[k]));
                        errors++;
                    end
                end
            end
        end
    end

    function automatic logic [FIELD_W-1:0] rand_field();
        case ($urandom_range(0, 5))
            0: return FIELD_W'(MAX_FIELD);
            1: return FIELD_W'(-MAX_FIELD - 1);
            default: return FIELD_W'($urandom());
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] near(logic [FIELD_W-1:0] base, int span);
        return FIELD_W'(longint'($signed(base)) + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int span;
        int vspan;
        span = (radius_q < 8) ? 8 : int'(radius_q * 3 / 2);
        vspan = 1 << $urandom_range(4, 22);
        if ($urandom_range(0, 9) == 0)
        begin
            for (int k = 0; k < 12; k++)
                p[k] = rand_field();
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                p[k] = ($urandom_range(0, 7) == 0) ? rand_field()
                                                   : near('0, 1 << $urandom_range(8, 22));
                p[3 + k] = ($urandom_range(0, 7) == 0) ? p[k] : near(p[k], span);
                p[6 + k] = ($urandom_range(0, 9) == 0) ? rand_field() : near('0, vspan);
                p[9 + k] = ($urandom_range(0, 9) == 0) ? rand_field() : near('0, vspan);
            end
        end
        return p;
    endfunction

    task automatic write_cfg(logic [CFG_W-1:0] radius, logic [CFG_W-1:0] rest);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= spcr_pkg::CFG_RADIUS;
        cfg_wdata <= radius;
        @(posedge clk);
        cfg_index <= spcr_pkg::CFG_REST;
        cfg_wdata <= rest;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        radius_q = longint'(radius);
        rest_q = longint'(rest[REST_W-1:0]);
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_pairs.size() > 0 || pin.valid || resolved_pairs.size() > 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic add_pair(longint ax, longint ay, longint az, longint bx, longint by,
                            longint bz, longint avx, longint avy, longint avz, longint bvx,
                            longint bvy, longint bvz);
        pending_pairs.push_back({FIELD_W'(bvz), FIELD_W'(bvy), FIELD_W'(bvx), FIELD_W'(avz),
                                 FIELD_W'(avy), FIELD_W'(avx), FIELD_W'(bz), FIELD_W'(by),
                                 FIELD_W'(bx), FIELD_W'(az), FIELD_W'(ay), FIELD_W'(ax)});
    endtask

    initial
    begin
        longint mx;
        longint mn;
        mx = MAX_FIELD;
        mn = -MAX_FIELD - 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // directed pairs at reset configuration
        add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 3, 2, 1, 65536, 0, 0, -65536, 0, 0);
        add_pair(0, 0, 0, 32768, 0, 0, 65536, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 65536, 0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 40000, 10000, -5000, 0, 0, 0, 65536, 0, 0);
        add_pair(0, 0, 0, 40000, 10000, -5000, 65536, 32768, 0, -65536, 0, 0);
        add_pair(mx, mx, mx, mx, mx, mx, mx, mx, mx, mn, mn, mn);
        add_pair(mn, mn, mn, mn, mn, mn, mn, mn, mn, mx, mx, mx);
        add_pair(mx, 0, 0, mx - 1000, 0, 0, mn, 0, 0, mx, 0, 0);
        add_pair(mn, 0, 0, mn, 0, 0, mx, mx, mx, mn, mn, mn);
        add_pair(mn, mn, mn, mx, mx, mx, 1, 2, 3, -1, -2, -3);
        add_pair(0, 100, 0, 0, -20000, 0, 0, -300000, 0, 0, 300000, 0);
        drain();
        write_cfg(20'd0, 20'd0);
        add_pair(0, 0, 0, 0, 0, 0, 5, 5, 5, -5, -5, -5);
        add_pair(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();
        write_cfg(20'd1048575, 20'd65536);
        add_pair(0, 0, 0, 0, 0, 0, 65536, 0, 0, -65536, 0, 0);
        add_pair(mx, mx, mx, mx - 5, mx, mx, mx, 0, 0, mn, 0, 0);
        add_pair(mn, 0, 0, mn + 300000, 0, 0, mx, 0, 0, mn, 0, 0);
        drain();
        write_cfg(20'd32768, 20'd131071);
        add_pair(0, 0, 0, 50000, 0, 0, 65536, 0, 0, -65536, 0, 0);
        drain();
        // random phases over several settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_cfg(20'd32768, 20'd29491);
                1: write_cfg(20'd1048575, 20'd131071);
                2: write_cfg(20'd1, 20'd0);
                3: write_cfg(20'd65536, 20'd65536);
                default: write_cfg(CFG_W'($urandom_range(0, 1048575)),
                                   CFG_W'($urandom_range(0, 131071)));
            endcase
            for (int i = 0; i < 100; i++)
                pending_pairs.push_back(random_pair());
            drain();
        end
        $display("%0d pairs checked, %0d of them in contact, over 10 radius/restitution settings",
                 checked, collided);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("simulation failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/spcr_pkg.sv
rtl/core/spcr_in_if.sv
rtl/core/spcr_out_if.sv
rtl/core/sphere_pair_collision_resolve.sv
tb/tb_sphere_pair_collision_resolve.sv
